@@ sv/smfl_pkg.sv @@
// Shared types, codes and helpers for the secure module frame link.
package smfl_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [7:0] BYTE_ONES    = 8'hff;
    localparam logic [15:0] STATUS_OK   = 16'h9000;
    localparam logic [7:0] MAC_SW1      = 8'h69;
    localparam logic [7:0] MAC_SW2      = 8'h89;
    localparam logic [7:0] MAC_CNT_MAX  = 8'd202;
    localparam logic [7:0] MAC_CNT_ALARM = 8'd200;

    localparam logic [13:0] POLL_LIMIT_RST = 14'd10000;
    localparam logic [15:0] MAX_LENGTH_RST = 16'd2048;

    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    localparam logic ACT_HOST = 1'b0;
    localparam logic ACT_RX   = 1'b1;

    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [2:0] OUT_OK       = 3'd0;
    localparam logic [2:0] OUT_TIMEOUT  = 3'd1;
    localparam logic [2:0] OUT_STATUS   = 3'd2;
    localparam logic [2:0] OUT_LENGTH   = 3'd3;
    localparam logic [2:0] OUT_CHECKSUM = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SEND,
        PH_HUNT,
        PH_STAT1,
        PH_STAT2,
        PH_LEN1,
        PH_LEN2,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [2:0]  outcome;
        logic [15:0] status_word;
        logic        mac_alarm;
    } result_t;

    // Up to three results caused by one input transaction.
    typedef struct packed {
        logic [1:0]  cnt;
        result_t [2:0] res;
    } bundle_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } qhead_t;

    function automatic result_t make_res(logic [1:0] kind, logic [7:0] value,
                                         logic [2:0] outcome, logic [15:0] sw,
                                         logic alarm);
        result_t r;
        r.kind        = kind;
        r.value       = value;
        r.outcome     = outcome;
        r.status_word = sw;
        r.mac_alarm   = alarm;
        return r;
    endfunction

endpackage

@@ sv/smfl_front.sv @@
// Front end: config registers, framing/parsing state machine, result bundles.
module smfl_front
    import smfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       fire,
    input  logic       action,
    input  logic [7:0] data_byte,
    input  logic       final_req,
    output logic       push,
    output bundle_t    push_bundle
);

    phase_t      phase_reg, phase_next;
    logic [13:0] poll_limit_reg;
    logic [15:0] max_length_reg;
    logic [7:0]  check_reg, check_next;
    logic [13:0] poll_count_reg, poll_count_next;
    logic [15:0] reply_length_reg, reply_length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  first_status_reg, first_status_next;
    logic [7:0]  mac_count_reg, mac_count_next;

    logic [13:0] poll_inc;
    logic        timeout;
    logic [15:0] len_full;
    logic [15:0] payload_inc;
    logic [15:0] sw;
    logic [7:0]  send_acc;
    bundle_t     bundle;

    assign poll_inc    = poll_count_reg + 14'd1;
    assign timeout     = (poll_inc >= poll_limit_reg) || (poll_inc == '0);
    assign len_full    = {reply_length_reg[15:8], data_byte};
    assign payload_inc = payload_count_reg + 16'd1;
    assign sw          = {first_status_reg, data_byte};
    // Checksum restarts at the first host byte of a frame.
    assign send_acc    = ((phase_reg == PH_IDLE) ? 8'h00 : check_reg) ^ data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_LIMIT_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_LIMIT: poll_limit_reg <= cfg_data[13:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            check_reg         <= '0;
            poll_count_reg    <= '0;
            reply_length_reg  <= '0;
            payload_count_reg <= '0;
            first_status_reg  <= '0;
            mac_count_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            check_reg         <= check_next;
            poll_count_reg    <= poll_count_next;
            reply_length_reg  <= reply_length_next;
            payload_count_reg <= payload_count_next;
            first_status_reg  <= first_status_next;
            mac_count_reg     <= mac_count_next;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (action == ACT_HOST)
        begin
            unique case (phase_reg)
                PH_IDLE, PH_SEND: phase_next = final_req ? PH_HUNT : PH_SEND;
                PH_HUNT, PH_STAT1, PH_STAT2, PH_LEN1, PH_LEN2, PH_PAYLOAD,
                PH_CHECK: phase_next = phase_reg;
                default: phase_next = PH_IDLE;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == SYNC_BYTE)
                        phase_next = PH_STAT1;
                    else if (timeout)
                        phase_next = PH_IDLE;
                end
                PH_STAT1: phase_next = PH_STAT2;
                PH_STAT2: phase_next = (sw == STATUS_OK) ? PH_LEN1 : PH_IDLE;
                PH_LEN1:  phase_next = PH_LEN2;
                PH_LEN2:
                begin
                    if (len_full > max_length_reg)
                        phase_next = PH_IDLE;
                    else if (len_full == '0)
                        phase_next = PH_CHECK;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (payload_inc >= reply_length_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK: phase_next = PH_IDLE;
                PH_IDLE, PH_SEND: phase_next = phase_reg;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Results and datapath updates
    always_comb
    begin
        bundle             = '0;
        check_next         = check_reg;
        poll_count_next    = poll_count_reg;
        reply_length_next  = reply_length_reg;
        payload_count_next = payload_count_reg;
        first_status_next  = first_status_reg;
        mac_count_next     = mac_count_reg;
        if (action == ACT_HOST)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    bundle.res[0] = make_res(KIND_SEND, SYNC_BYTE, OUT_OK, '0, 1'b0);
                    bundle.res[1] = make_res(KIND_SEND, data_byte, OUT_OK, '0, 1'b0);
                    bundle.res[2] = make_res(KIND_SEND, send_acc ^ BYTE_ONES, OUT_OK,
                                             '0, 1'b0);
                    bundle.cnt    = final_req ? 2'd3 : 2'd2;
                    check_next    = send_acc;
                    if (final_req)
                        poll_count_next = '0;
                end
                PH_SEND:
                begin
                    bundle.res[0] = make_res(KIND_SEND, data_byte, OUT_OK, '0, 1'b0);
                    bundle.res[1] = make_res(KIND_SEND, send_acc ^ BYTE_ONES, OUT_OK,
                                             '0, 1'b0);
                    bundle.cnt    = final_req ? 2'd2 : 2'd1;
                    check_next    = send_acc;
                    if (final_req)
                        poll_count_next = '0;
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == SYNC_BYTE)
                        check_next = '0;
                    else
                    begin
                        poll_count_next = poll_inc;
                        if (timeout)
                        begin
                            bundle.res[0] = make_res(KIND_END, '0, OUT_TIMEOUT, '0, 1'b0);
                            bundle.cnt    = 2'd1;
                        end
                    end
                end
                PH_STAT1:
                begin
                    first_status_next = data_byte;
                    check_next        = check_reg ^ data_byte;
                end
                PH_STAT2:
                begin
                    check_next = check_reg ^ data_byte;
                    if (sw != STATUS_OK)
                    begin
                        bundle.res[0] = make_res(KIND_END, '0, OUT_STATUS, sw, 1'b0);
                        bundle.cnt    = 2'd1;
                        if ((first_status_reg == MAC_SW1 || data_byte == MAC_SW2)
                            && mac_count_reg < MAC_CNT_MAX)
                        begin
                            mac_count_next = mac_count_reg + 8'd1;
                            bundle.res[0].mac_alarm =
                                (mac_count_reg + 8'd1) == MAC_CNT_ALARM;
                        end
                    end
                end
                PH_LEN1:
                begin
                    reply_length_next = {data_byte, 8'h00};
                    check_next        = check_reg ^ data_byte;
                    bundle.res[0]     = make_res(KIND_REPLY, data_byte, OUT_OK, '0, 1'b0);
                    bundle.cnt        = 2'd1;
                end
                PH_LEN2:
                begin
                    reply_length_next = len_full;
                    check_next        = check_reg ^ data_byte;
                    bundle.res[0]     = make_res(KIND_REPLY, data_byte, OUT_OK, '0, 1'b0);
                    bundle.res[1]     = make_res(KIND_END, '0, OUT_LENGTH, STATUS_OK, 1'b0);
                    bundle.cnt        = (len_full > max_length_reg) ? 2'd2 : 2'd1;
                    payload_count_next = '0;
                end
                PH_PAYLOAD:
                begin
                    check_next         = check_reg ^ data_byte;
                    payload_count_next = payload_inc;
                    bundle.res[0]      = make_res(KIND_REPLY, data_byte, OUT_OK, '0, 1'b0);
                    bundle.cnt         = 2'd1;
                end
                PH_CHECK:
                begin
                    bundle.res[0] = make_res(KIND_END, '0,
                        (data_byte == (check_reg ^ BYTE_ONES)) ? OUT_OK : OUT_CHECKSUM,
                        STATUS_OK, 1'b0);
                    bundle.cnt    = 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign push        = fire && (bundle.cnt != 2'd0);
    assign push_bundle = bundle;

endmodule

@@ sv/smfl_queue.sv @@
// Short bundle queue between the front and back ends.
module smfl_queue
    import smfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output logic    full,
    output qhead_t  head
);

    bundle_t      mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.bundle = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QAW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QAW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/smfl_back.sv @@
// Back end: unrolls each bundle into single results behind an output register.
module smfl_back
    import smfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  qhead_t  head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic    out_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    result_t    res_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = head.valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == (head.bundle.cnt - 2'd1));
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.bundle.res[idx_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

@@ sv/secure_module_frame_link.sv @@
// Top level of the secure module frame link.
// Frames a host command toward a security module (sync byte, host bytes, inverted
// XOR checksum) and parses the module's reply (sync hunt with poll timeout,
// status word, length, payload, checksum). One input transaction is accepted per
// clock as long as the four-entry result queue between the state machine and the
// output stage has room; a transaction causes zero to three results, and the
// output stage delivers one result per clock while out_ready is high, so the
// sustained rate is one item per cycle when each item yields at most one result
// and else is set by the output stage. Configuration writes take effect at once.
module secure_module_frame_link
    import smfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        final_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic        run_last,
    output logic [2:0]  outcome,
    output logic [15:0] status_word,
    output logic        mac_alarm
);

    logic    fire;
    logic    push;
    logic    pop;
    logic    full;
    bundle_t push_bundle;
    qhead_t  head;
    result_t res;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    smfl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fire        (fire),
        .action      (action),
        .data_byte   (data_byte),
        .final_req   (final_req),
        .push        (push),
        .push_bundle (push_bundle)
    );

    smfl_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (full),
        .head        (head)
    );

    smfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res),
        .out_last  (run_last)
    );

    assign kind        = res.kind;
    assign value       = res.value;
    assign outcome     = res.outcome;
    assign status_word = res.status_word;
    assign mac_alarm   = res.mac_alarm;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for secure_module_frame_link: directed tests then random traffic.
module tb;
    import smfl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 31;
    localparam int SETTLE_CYC  = 8;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        run_last;
        logic [2:0]  outcome;
        logic [15:0] status_word;
        logic        mac_alarm;
    } link_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  data_byte;
    logic        final_req;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        run_last;
    logic [2:0]  outcome;
    logic [15:0] status_word;
    logic        mac_alarm;

    // model copy of the block state and registers
    phase_t      ph;
    logic [7:0]  acc;
    logic [13:0] polls;
    logic [15:0] rlen;
    logic [15:0] pcnt;
    logic [7:0]  st1;
    logic [7:0]  macs;
    logic [13:0] poll_lim;
    logic [15:0] max_len;

    link_result_t results_due[$];
    int          errors;
    int          items_sent;
    int          results_checked;
    int          cycles;
    int          end_tally[5];
    int          alarms_seen;
    bit          no_stall;

    secure_module_frame_link i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_byte   (data_byte),
        .final_req   (final_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .run_last    (run_last),
        .outcome     (outcome),
        .status_word (status_word),
        .mac_alarm   (mac_alarm)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic link_result_t result_of(input logic [1:0] k, input logic [7:0] v,
                                               input logic [2:0] o, input logic [15:0] s,
                                               input logic a);
        link_result_t r;
        r.kind        = k;
        r.value       = v;
        r.run_last    = 1'b0;
        r.outcome     = o;
        r.status_word = s;
        r.mac_alarm   = a;
        return r;
    endfunction

    // Advance the link model by one accepted transaction and queue what it emits.
    task automatic step_link(input logic act, input logic [7:0] b, input logic fin);
        link_result_t made[3];
        int           n;
        logic [15:0]  sw;
        logic         alarm;
        n = 0;
        if (act == ACT_HOST)
        begin
            if (ph == PH_IDLE)
            begin
                made[n] = result_of(KIND_SEND, SYNC_BYTE, OUT_OK, 16'h0, 1'b0);
                n++;
                acc = 8'h00;
                ph  = PH_SEND;
            end
            if (ph == PH_SEND)
            begin
                made[n] = result_of(KIND_SEND, b, OUT_OK, 16'h0, 1'b0);
                n++;
                acc ^= b;
                if (fin)
                begin
                    made[n] = result_of(KIND_SEND, acc ^ BYTE_ONES, OUT_OK, 16'h0, 1'b0);
                    n++;
                    ph    = PH_HUNT;
                    polls = '0;
                end
            end
        end
        else
        begin
            case (ph)
                PH_HUNT:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        acc = 8'h00;
                        ph  = PH_STAT1;
                    end
                    else
                    begin
                        polls = polls + 14'd1;
                        if (polls >= poll_lim || polls == '0)
                        begin
                            made[n] = result_of(KIND_END, 8'h00, OUT_TIMEOUT, 16'h0, 1'b0);
                            n++;
                            ph = PH_IDLE;
                        end
                    end
                end
                PH_STAT1:
                begin
                    st1 = b;
                    acc ^= b;
                    ph  = PH_STAT2;
                end
                PH_STAT2:
                begin
                    sw = {st1, b};
                    acc ^= b;
                    if (sw != STATUS_OK)
                    begin
                        alarm = 1'b0;
                        if ((st1 == MAC_SW1 || b == MAC_SW2) && macs < MAC_CNT_MAX)
                        begin
                            macs  = macs + 8'd1;
                            alarm = (macs == MAC_CNT_ALARM);
                        end
                        made[n] = result_of(KIND_END, 8'h00, OUT_STATUS, sw, alarm);
                        n++;
                        ph = PH_IDLE;
                    end
                    else
                        ph = PH_LEN1;
                end
                PH_LEN1:
                begin
                    rlen = {b, 8'h00};
                    acc ^= b;
                    made[n] = result_of(KIND_REPLY, b, OUT_OK, 16'h0, 1'b0);
                    n++;
                    ph = PH_LEN2;
                end
                PH_LEN2:
                begin
                    rlen[7:0] = b;
                    acc ^= b;
                    made[n] = result_of(KIND_REPLY, b, OUT_OK, 16'h0, 1'b0);
                    n++;
                    if (rlen > max_len)
                    begin
                        made[n] = result_of(KIND_END, 8'h00, OUT_LENGTH, STATUS_OK, 1'b0);
                        n++;
                        ph = PH_IDLE;
                    end
                    else if (rlen == 16'h0)
                        ph = PH_CHECK;
                    else
                    begin
                        pcnt = 16'h0;
                        ph   = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    acc ^= b;
                    made[n] = result_of(KIND_REPLY, b, OUT_OK, 16'h0, 1'b0);
                    n++;
                    pcnt = pcnt + 16'd1;
                    if (pcnt >= rlen)
                        ph = PH_CHECK;
                end
                PH_CHECK:
                begin
                    made[n] = result_of(KIND_END, 8'h00,
                                        (b == (acc ^ BYTE_ONES)) ? OUT_OK : OUT_CHECKSUM,
                                        STATUS_OK, 1'b0);
                    n++;
                    ph = PH_IDLE;
                end
                default: ;
            endcase
        end
        if (n > 0)
            made[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            results_due.push_back(made[i]);
            if (made[i].kind == KIND_END)
                end_tally[made[i].outcome]++;
            if (made[i].mac_alarm)
                alarms_seen++;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        link_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: kind 0x%0h value 0x%0h", kind, value);
                errors++;
            end
            else
            begin
                exp_r = results_due.pop_front();
                check_field("kind", exp_r.kind, kind);
                check_field("value", exp_r.value, value);
                check_field("run_last", exp_r.run_last, run_last);
                check_field("outcome", exp_r.outcome, outcome);
                check_field("status_word", exp_r.status_word, status_word);
                check_field("mac_alarm", exp_r.mac_alarm, mac_alarm);
                results_checked++;
            end
        end
    end

    // Present one transaction at a falling edge and hold it until accepted.
    task automatic send_item(input logic act, input logic [7:0] b, input logic fin);
        @(negedge clk);
        while (!no_stall && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        action    = act;
        data_byte = b;
        final_req = fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_link(act, b, fin);
        items_sent++;
    endtask

    // Drop valid, wait for every queued result, then let the pipeline go quiet.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        settle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_POLL_LIMIT)
            poll_lim = data[13:0];
        else
            max_len = data;
    endtask

    task automatic write_poll_limit(input int lim);
        logic [15:0] d;
        d       = 16'($urandom);
        d[13:0] = lim[13:0];
        write_reg(CFG_POLL_LIMIT, d);
    endtask

    function automatic logic [7:0] non_sync();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == SYNC_BYTE)
            b = ~b;
        return b;
    endfunction

    task automatic send_frame(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_item(ACT_HOST, 8'($urandom), i == nbytes - 1);
    endtask

    task automatic send_noise_polls(input int cnt);
        for (int i = 0; i < cnt; i++)
            send_item(ACT_RX, non_sync(), 1'($urandom));
    endtask

    // Module reply: junk, sync, status; length if accepted; payload, checksum if in range.
    task automatic send_reply(input logic [15:0] sw, input logic [15:0] len, input bit ck_ok,
                              input int junk);
        logic [7:0] sum;
        logic [7:0] b;
        send_noise_polls(junk);
        send_item(ACT_RX, SYNC_BYTE, 1'($urandom));
        send_item(ACT_RX, sw[15:8], 1'($urandom));
        send_item(ACT_RX, sw[7:0], 1'($urandom));
        sum = sw[15:8] ^ sw[7:0];
        if (sw == STATUS_OK)
        begin
            send_item(ACT_RX, len[15:8], 1'($urandom));
            send_item(ACT_RX, len[7:0], 1'($urandom));
            sum ^= len[15:8] ^ len[7:0];
            if (len <= max_len)
            begin
                for (int i = 0; i < int'(len); i++)
                begin
                    b = 8'($urandom);
                    sum ^= b;
                    send_item(ACT_RX, b, 1'($urandom));
                end
                b = ~sum;
                if (!ck_ok)
                    b[$urandom_range(0, 7)] ^= 1'b1;
                send_item(ACT_RX, b, 1'($urandom));
            end
        end
    endtask

    task automatic test_reset_values();
        send_frame(2);
        send_reply(STATUS_OK, 16'd3, 1'b1, 1);
        send_frame(1);
        send_reply(STATUS_OK, MAX_LENGTH_RST, 1'b1, 0);
        send_frame(1);
        send_reply(STATUS_OK, MAX_LENGTH_RST + 16'd1, 1'b1, 0);
        // default poll limit runs out on the last junk byte
        send_frame(1);
        send_noise_polls(int'(POLL_LIMIT_RST));
    endtask

    task automatic test_framing();
        logic [7:0] ck;
        send_item(ACT_RX, SYNC_BYTE, 1'b1);
        send_item(ACT_RX, 8'hff, 1'b0);
        send_item(ACT_HOST, 8'h00, 1'b0);
        send_item(ACT_RX, SYNC_BYTE, 1'b1);
        send_item(ACT_HOST, 8'hff, 1'b0);
        send_item(ACT_HOST, 8'h5a, 1'b1);
        send_item(ACT_HOST, 8'h12, 1'b1);
        send_item(ACT_RX, SYNC_BYTE, 1'b0);
        send_item(ACT_RX, 8'h90, 1'b0);
        send_item(ACT_RX, 8'h00, 1'b1);
        send_item(ACT_HOST, 8'hff, 1'b1);
        send_item(ACT_RX, 8'h00, 1'b0);
        send_item(ACT_RX, 8'h01, 1'b0);
        send_item(ACT_HOST, 8'h00, 1'b0);
        send_item(ACT_RX, 8'ha7, 1'b0);
        ck = ~(8'h90 ^ 8'h01 ^ 8'ha7);
        send_item(ACT_RX, ck, 1'b0);
        send_item(ACT_HOST, 8'hff, 1'b1);
        send_reply(STATUS_OK, 16'd0, 1'b1, 0);
    endtask

    task automatic test_status();
        logic [15:0] words[7];
        words = '{STATUS_OK, {MAC_SW1, 8'h00}, {8'h12, MAC_SW2}, {MAC_SW1, MAC_SW2},
                  16'h9001, 16'h0000, 16'hffff};
        foreach (words[i])
        begin
            send_frame(1);
            send_reply(words[i], 16'd0, 1'b1, 0);
        end
    endtask

    task automatic test_length();
        write_reg(CFG_MAX_LENGTH, 16'd0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd0, 1'b1, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd0, 1'b0, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd1, 1'b1, 0);
        write_reg(CFG_MAX_LENGTH, 16'd4);
        send_frame(3);
        send_reply(STATUS_OK, 16'd4, 1'b1, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd4, 1'b0, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd5, 1'b1, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'hffff, 1'b1, 0);
        write_reg(CFG_MAX_LENGTH, 16'hffff);
        send_frame(1);
        send_reply(STATUS_OK, 16'h0100, 1'b1, 0);
        send_frame(1);
        send_reply(STATUS_OK, 16'd2, 1'b1, 0);
    endtask

    task automatic test_poll();
        write_poll_limit(0);
        send_frame(1);
        send_noise_polls(1);
        write_poll_limit(1);
        send_frame(1);
        send_noise_polls(1);
        send_frame(1);
        send_reply(STATUS_OK, 16'd1, 1'b1, 0);
        write_poll_limit(3);
        send_frame(2);
        send_reply(STATUS_OK, 16'd1, 1'b1, 2);
        send_frame(1);
        send_noise_polls(3);
        write_poll_limit(16383);
        send_frame(1);
        send_reply(STATUS_OK, 16'd2, 1'b1, 5);
    endtask

    // Enough MAC rejections to pass the alarm and hit the saturation point.
    task automatic test_mac_saturation();
        logic [15:0] sw;
        repeat (int'(MAC_CNT_MAX) + 4)
        begin
            if ($urandom_range(0, 1))
                sw = {MAC_SW1, 8'($urandom)};
            else
                sw = {8'($urandom), MAC_SW2};
            send_frame(1);
            send_reply(sw, 16'd0, 1'b1, 0);
        end
    endtask

    task automatic random_traffic(input int n_items, input bit noisy);
        int          stop_at;
        int          pick;
        int          cap;
        logic [15:0] sw;
        logic [15:0] len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (noisy && pick < 12)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(1'($urandom), 8'($urandom), 1'($urandom));
            end
            else if (noisy && pick < 18)
            begin
                // truncated reply, left hanging in the status bytes
                send_frame($urandom_range(1, 3));
                send_item(ACT_RX, SYNC_BYTE, 1'b0);
                send_item(ACT_RX, 8'h90, 1'b0);
            end
            else
            begin
                send_frame(($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 4));
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    sw = STATUS_OK;
                else if (pick < 80)
                    sw = {MAC_SW1, 8'($urandom)};
                else if (pick < 90)
                    sw = {8'($urandom), MAC_SW2};
                else
                    sw = 16'($urandom);
                cap = (max_len > 16'd8) ? 8 : int'(max_len);
                if ($urandom_range(0, 9) < 8)
                    len = 16'($urandom_range(0, cap + 2));
                else
                begin
                    len = 16'($urandom);
                    if (len <= max_len)
                        len = len % 16'd9;
                end
                send_reply(sw, len, $urandom_range(0, 4) != 0,
                           ($urandom_range(0, 99) < 15) ? $urandom_range(0, 8)
                                                        : $urandom_range(0, 2));
            end
        end
    endtask

    task automatic test_random();
        write_poll_limit($urandom_range(1, 6));
        write_reg(CFG_MAX_LENGTH, 16'($urandom_range(0, 10)));
        random_traffic(105, 1'b1);
        write_poll_limit(16383);
        write_reg(CFG_MAX_LENGTH, 16'hffff);
        random_traffic(105, 1'b0);
        write_poll_limit($urandom_range(1, 4));
        write_reg(CFG_MAX_LENGTH, 16'($urandom_range(0, 6)));
        settle();
        no_stall = 1'b1;
        random_traffic(100, 1'b1);
        settle();
        no_stall = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POLL_LIMIT;
        cfg_data  = 16'h0;
        in_valid  = 1'b0;
        action    = ACT_HOST;
        data_byte = 8'h00;
        final_req = 1'b0;
        out_ready = 1'b0;
        no_stall  = 1'b0;
        errors    = 0;
        ph        = PH_IDLE;
        acc       = 8'h00;
        polls     = '0;
        rlen      = 16'h0;
        pcnt      = 16'h0;
        st1       = 8'h00;
        macs      = 8'h00;
        poll_lim  = POLL_LIMIT_RST;
        max_len   = MAX_LENGTH_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_framing();
        test_status();
        test_length();
        test_poll();
        test_mac_saturation();
        test_random();
        settle();

        $display("tb: %0d input transactions sent, %0d results compared, %0d mac alarms",
                 items_sent, results_checked, alarms_seen);
        $display("tb: ends ok %0d, timeout %0d, status %0d, length %0d, checksum %0d",
                 end_tally[OUT_OK], end_tally[OUT_TIMEOUT], end_tally[OUT_STATUS],
                 end_tally[OUT_LENGTH], end_tally[OUT_CHECKSUM]);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/smfl_pkg.sv
sv/smfl_front.sv
sv/smfl_queue.sv
sv/smfl_back.sv
sv/secure_module_frame_link.sv
test/tb.sv
